/* src/tlwq_pkg.sv */
// ----------------------------------------------------------------------------
// tlwq_pkg
// Operation, status and action state codes for the transfer lane window
// queues block.
// ----------------------------------------------------------------------------
package tlwq_pkg;

    localparam int FUNC_BITS   = 3;
    localparam int STATUS_BITS = 2;
    localparam int STATE_BITS  = 2;

    localparam logic [FUNC_BITS-1:0] FUNC_ENQUEUE  = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_CLAIM    = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_PUBLISH  = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_QUERY    = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_COMPLETE = 3'd4;

    localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_REFUSED = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd2;

    localparam logic [STATE_BITS-1:0] ACT_NONE     = 2'd0;
    localparam logic [STATE_BITS-1:0] ACT_PENDING  = 2'd1;
    localparam logic [STATE_BITS-1:0] ACT_INFLIGHT = 2'd2;

    typedef logic [FUNC_BITS-1:0]   func_t;
    typedef logic [STATUS_BITS-1:0] status_t;
    typedef logic [STATE_BITS-1:0]  act_state_t;

    // Queue occupancy flags handed from a queue to the control logic
    typedef struct packed {
        logic empty;
        logic full;
    } q_flags_t;

endpackage

/* src/tlwq_queue.sv */
// ----------------------------------------------------------------------------
// tlwq_queue
// In-order tag queue in a memory, with the head entry kept in a register
// so the next operation sees it without a read cycle.
// ----------------------------------------------------------------------------
module tlwq_queue
    import tlwq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output q_flags_t         flags
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    head_reg;
    logic [AW-1:0]    head_next;
    logic [AW-1:0]    tail_reg;
    logic [AW-1:0]    tail_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [WIDTH-1:0] head_data_reg;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        head_next  = pop ? ptr_inc(head_reg) : head_reg;
        tail_next  = push ? ptr_inc(tail_reg) : tail_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_data;
        end
    end

    // Track the entry at the new head; forward a push that lands there
    always_ff @(posedge clk)
    begin
        if (push && (tail_reg == head_next))
        begin
            head_data_reg <= push_data;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

    assign head_data   = head_data_reg;
    assign flags.empty = (count_reg == '0);
    assign flags.full  = (count_reg == CW'(DEPTH));

endmodule

/* src/transfer_lane_window_queues_core.sv */
// ----------------------------------------------------------------------------
// transfer_lane_window_queues_core
// Foreground, background and inflight tag queues with a per-action state
// table and a byte window on background claims.
// ----------------------------------------------------------------------------
// Result: an accepted transaction passes the input register, then the result register that drives done.
// Throughput: one transaction per cycle while busy is low; the receiver cannot stall.
// The state table lookup is registered at accept; queue heads are registered.
// Reset: queues empty, bytes and window zero; busy stays high while a
// sweep clears the action state table.
module transfer_lane_window_queues_core
    import tlwq_pkg::*;
#(
    parameter int TAG_BITS    = 6,
    parameter int QUEUE_DEPTH = 16,
    parameter int SIZE_BITS   = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           func,
    input  logic [TAG_BITS-1:0]  action_id,
    input  logic                 background,
    input  logic [SIZE_BITS-1:0] obj_bytes,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SIZE_BITS-1:0] cfg_data,
    output logic                 done,
    output logic [1:0]           status,
    output logic                 is_inflight_head,
    output logic [SIZE_BITS-1:0] inflight_bytes
);

    localparam int TAG_COUNT = 1 << TAG_BITS;

    logic                 accept;

    // Sweep that clears the state table after reset
    logic                 clr_active_reg;
    logic [TAG_BITS-1:0]  clr_addr_reg;

    act_state_t           st_mem [TAG_COUNT];
    logic                 st_we;
    logic [TAG_BITS-1:0]  st_wa;
    act_state_t           st_wd;
    act_state_t           st_rd_reg;

    logic                 vld_reg;
    func_t                func_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic                 bg_reg;
    logic [SIZE_BITS-1:0] size_reg;

    logic [SIZE_BITS-1:0] window_reg;
    logic [SIZE_BITS-1:0] bytes_reg;
    logic [SIZE_BITS-1:0] bytes_next;

    logic                 done_reg;
    status_t              status_reg;
    status_t              status_next;
    logic                 ihead_reg;
    logic                 ihead_next;

    logic                 fg_push;
    logic                 fg_pop;
    logic                 bgq_push;
    logic                 bgq_pop;
    logic                 if_push;
    logic                 if_pop;
    logic [TAG_BITS-1:0]  fg_head;
    logic [TAG_BITS-1:0]  bgq_head;
    logic [TAG_BITS-1:0]  if_head;
    q_flags_t             fg_flags;
    q_flags_t             bgq_flags;
    q_flags_t             if_flags;

    logic                 p_full;
    logic                 p_match;
    logic                 if_match;
    logic                 admit;
    logic [SIZE_BITS:0]   sum;

    assign busy      = clr_active_reg;
    assign accept    = start && !clr_active_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (cfg_valid)
        begin
            window_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {TAG_BITS{1'b1}})
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            tag_reg  <= action_id;
            bg_reg   <= background;
            size_reg <= obj_bytes;
        end
    end

    // State table: one write port, one registered read with write forwarding
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            st_mem[clr_addr_reg] <= ACT_NONE;
        end
        else if (st_we)
        begin
            st_mem[st_wa] <= st_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (st_we && (st_wa == action_id))
            begin
                st_rd_reg <= st_wd;
            end
            else
            begin
                st_rd_reg <= st_mem[action_id];
            end
        end
    end

    tlwq_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (TAG_BITS)
    ) u_fg_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fg_push),
        .push_data (tag_reg),
        .pop       (fg_pop),
        .head_data (fg_head),
        .flags     (fg_flags)
    );

    tlwq_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (TAG_BITS)
    ) u_bg_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (bgq_push),
        .push_data (tag_reg),
        .pop       (bgq_pop),
        .head_data (bgq_head),
        .flags     (bgq_flags)
    );

    tlwq_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (TAG_BITS)
    ) u_if_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (if_push),
        .push_data (tag_reg),
        .pop       (if_pop),
        .head_data (if_head),
        .flags     (if_flags)
    );

    // Operation decode for the transaction in the input register
    always_comb
    begin
        p_full   = bg_reg ? bgq_flags.full : fg_flags.full;
        p_match  = bg_reg ? (!bgq_flags.empty && (bgq_head == tag_reg))
                          : (!fg_flags.empty && (fg_head == tag_reg));
        if_match = !if_flags.empty && (if_head == tag_reg) &&
                   (st_rd_reg == ACT_INFLIGHT);
        admit    = (window_reg == '0) || (bytes_reg == '0) ||
                   ((bytes_reg <= window_reg) &&
                    (size_reg <= (window_reg - bytes_reg)));
        sum      = {1'b0, bytes_reg} + {1'b0, size_reg};

        fg_push     = 1'b0;
        fg_pop      = 1'b0;
        bgq_push    = 1'b0;
        bgq_pop     = 1'b0;
        if_push     = 1'b0;
        if_pop      = 1'b0;
        st_we       = 1'b0;
        st_wa       = tag_reg;
        st_wd       = ACT_NONE;
        bytes_next  = bytes_reg;
        status_next = STATUS_REFUSED;
        ihead_next  = 1'b0;

        if (vld_reg)
        begin
            case (func_reg)
                FUNC_ENQUEUE:
                begin
                    if (p_full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        fg_push     = !bg_reg;
                        bgq_push    = bg_reg;
                        st_we       = 1'b1;
                        st_wd       = ACT_PENDING;
                        status_next = STATUS_OK;
                    end
                end
                FUNC_CLAIM:
                begin
                    if (p_match && (st_rd_reg == ACT_PENDING) && (!bg_reg || admit))
                    begin
                        fg_pop      = !bg_reg;
                        bgq_pop     = bg_reg;
                        st_we       = 1'b1;
                        st_wd       = ACT_NONE;
                        status_next = STATUS_OK;
                    end
                end
                FUNC_PUBLISH:
                begin
                    if (if_flags.full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        if_push     = 1'b1;
                        st_we       = 1'b1;
                        st_wd       = ACT_INFLIGHT;
                        status_next = STATUS_OK;
                        if (bg_reg)
                        begin
                            // saturate at the top of the byte range
                            bytes_next = sum[SIZE_BITS] ? {SIZE_BITS{1'b1}}
                                                        : sum[SIZE_BITS-1:0];
                        end
                    end
                end
                FUNC_QUERY:
                begin
                    ihead_next  = if_match;
                    status_next = STATUS_OK;
                end
                FUNC_COMPLETE:
                begin
                    if (if_match)
                    begin
                        if_pop      = 1'b1;
                        st_we       = 1'b1;
                        st_wd       = ACT_NONE;
                        status_next = STATUS_OK;
                        if (bg_reg)
                        begin
                            // floor at zero
                            bytes_next = (size_reg > bytes_reg) ? '0
                                                                : bytes_reg - size_reg;
                        end
                    end
                end
                default:
                begin
                    status_next = STATUS_REFUSED;
                end
            endcase
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            status_reg <= STATUS_OK;
            ihead_reg  <= 1'b0;
            bytes_reg  <= '0;
        end
        else
        begin
            done_reg <= vld_reg;
            if (vld_reg)
            begin
                status_reg <= status_next;
                ihead_reg  <= ihead_next;
                bytes_reg  <= bytes_next;
            end
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign is_inflight_head = ihead_reg;
    assign inflight_bytes   = bytes_reg;

endmodule

/* src/tlwq_checker.sv */
// ----------------------------------------------------------------------------
// tlwq_checker
// Port-level checks on the transfer lane window queues block.
// ----------------------------------------------------------------------------
module tlwq_checker
    import tlwq_pkg::*;
#(
    parameter int SIZE_BITS   = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [2:0]           func,
    input  logic                 done,
    input  logic [1:0]           status,
    input  logic                 is_inflight_head,
    input  logic [SIZE_BITS-1:0] inflight_bytes
);

    // Every accepted transaction yields a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted transaction produced no result");

    // No result without an earlier accepted transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without an accepted transaction");

    // Byte count moves only with a result
    a_bytes_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(inflight_bytes) |-> done)
        else $error("inflight bytes changed without a result");

    // A head hit is always an accepted query
    a_head_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_inflight_head) |-> (status == STATUS_OK) &&
            ($past(func, 2) == FUNC_QUERY))
        else $error("inflight head reported outside an accepted query");

endmodule

bind transfer_lane_window_queues_core tlwq_checker #(
    .SIZE_BITS (SIZE_BITS)
) u_tlwq_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .func             (func),
    .done             (done),
    .status           (status),
    .is_inflight_head (is_inflight_head),
    .inflight_bytes   (inflight_bytes)
);
